[src/softmax_row_tile_planner_top_macros.svh]
// Assertion macros used by the planner checker.
`ifndef SOFTMAX_ROW_TILE_PLANNER_TOP_MACROS_SVH
`define SOFTMAX_ROW_TILE_PLANNER_TOP_MACROS_SVH

// Clocked on clk, quiet while arst_n is low.
`define SMRTP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define SMRTP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	`SMRTP_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[src/smrtp_pkg.sv]
// Shared constants, types and the block-element table of the row tile planner.
`default_nettype none
package smrtp_pkg;

	localparam int BLOCK_BYTES = 32;
	localparam int ELEM_FLOAT  = 4;
	localparam int ELEM_HALF   = 2;
	localparam int BB_UNIT     = 64;
	localparam int BB_MIN      = 256;
	// Tile of rows used for alignment; BLOCK_BYTES is a power of two.
	localparam int TILE_ROWS   = BLOCK_BYTES / ELEM_FLOAT;

	localparam int OP_W    = 1;
	localparam int ROW_W   = 24;
	localparam int COL_W   = 16;
	localparam int EB_W    = 4;
	localparam int STAT_W  = 2;
	localparam int BLKO_W  = 6;
	localparam int ELEMS_W = 32;
	localparam int WS_W    = 20;
	localparam int BLK_W   = 9;
	localparam int DIV_W   = 24;

	localparam logic [WS_W-1:0] WS_RESET = WS_W'(37888);
	localparam logic [ELEMS_W-1:0] HALVE_LIMIT = ELEMS_W'(BB_UNIT * BB_MIN);

	localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_ZERO_ELEM = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_ZERO_DIM  = 2'd2;

	localparam int NUM_PROD = 6;
	localparam int PIDX_W   = 3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WDIV,
		ST_BB,
		ST_MODCHK,
		ST_MODW,
		ST_HMUL,
		ST_HCHK,
		ST_ZCHK,
		ST_RDIV,
		ST_PROD,
		ST_DONE
	} seq_state_t;

	// Elements of one block for a given element size; zero size maps to zero.
	function automatic logic [BLK_W-1:0] blk_of(input logic [EB_W-1:0] eb);
		logic [BLK_W-1:0] r;
		unique case (eb)
			4'd1:    r = BLK_W'(BLOCK_BYTES / 1);
			4'd2:    r = BLK_W'(BLOCK_BYTES / 2);
			4'd3:    r = BLK_W'(BLOCK_BYTES / 3);
			4'd4:    r = BLK_W'(BLOCK_BYTES / 4);
			4'd5:    r = BLK_W'(BLOCK_BYTES / 5);
			4'd6:    r = BLK_W'(BLOCK_BYTES / 6);
			4'd7:    r = BLK_W'(BLOCK_BYTES / 7);
			4'd8:    r = BLK_W'(BLOCK_BYTES / 8);
			4'd9:    r = BLK_W'(BLOCK_BYTES / 9);
			4'd10:   r = BLK_W'(BLOCK_BYTES / 10);
			4'd11:   r = BLK_W'(BLOCK_BYTES / 11);
			4'd12:   r = BLK_W'(BLOCK_BYTES / 12);
			4'd13:   r = BLK_W'(BLOCK_BYTES / 13);
			4'd14:   r = BLK_W'(BLOCK_BYTES / 14);
			4'd15:   r = BLK_W'(BLOCK_BYTES / 15);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[src/smrtp_if.sv]
// Request and response channel interfaces of the row tile planner.
`default_nettype none
interface smrtp_req_if;
	import smrtp_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [ROW_W-1:0]  row_count;
	logic [COL_W-1:0]  col_count;
	logic [EB_W-1:0]   elem_bytes;

	modport source (output valid, opcode, row_count, col_count, elem_bytes, input ready);
	modport sink   (input valid, opcode, row_count, col_count, elem_bytes, output ready);
endinterface

interface smrtp_rsp_if;
	import smrtp_pkg::*;
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [ROW_W-1:0]   split_rows;
	logic [ROW_W-1:0]   full_splits;
	logic [ROW_W-1:0]   tail_rows;
	logic [BLKO_W-1:0]  block_elems;
	logic [ELEMS_W-1:0] total_elems;
	logic [ELEMS_W-1:0] out_max_elems;
	logic [ELEMS_W-1:0] split_elems;
	logic [ELEMS_W-1:0] reduce_elems;
	logic [ELEMS_W-1:0] tail_split_elems;
	logic [ELEMS_W-1:0] tail_reduce_elems;

	modport source (output valid, status, split_rows, full_splits, tail_rows, block_elems,
		total_elems, out_max_elems, split_elems, reduce_elems, tail_split_elems,
		tail_reduce_elems, input ready);
	modport sink   (input valid, status, split_rows, full_splits, tail_rows, block_elems,
		total_elems, out_max_elems, split_elems, reduce_elems, tail_split_elems,
		tail_reduce_elems, output ready);
endinterface
`default_nettype wire

[src/smrtp_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module smrtp_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [smrtp_pkg::DIV_W-1:0] dividend,
	input  wire logic [smrtp_pkg::DIV_W-1:0] divisor,
	output logic                            done,
	output logic [smrtp_pkg::DIV_W-1:0]     quotient,
	output logic [smrtp_pkg::DIV_W-1:0]     remainder
);
	import smrtp_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   diff;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// keep the shifted remainder when the trial subtract goes negative
			rem_q <= diff[DIV_W] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ~diff[DIV_W]};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

[src/smrtp_mul.sv]
// Registered 24x16 multiplier, product kept modulo 2^32.
`default_nettype none
module smrtp_mul (
	input  wire logic                          clk,
	input  wire logic                          go,
	input  wire logic [smrtp_pkg::ROW_W-1:0]   a,
	input  wire logic [smrtp_pkg::COL_W-1:0]   b,
	output logic [smrtp_pkg::ELEMS_W-1:0]      product
);
	import smrtp_pkg::*;

	logic [ROW_W+COL_W-1:0] full;
	logic [ELEMS_W-1:0]     product_q;

	assign full = a * b;

	always_ff @(posedge clk) begin
		if (go) begin
			product_q <= full[ELEMS_W-1:0];
		end
	end

	assign product = product_q;

endmodule
`default_nettype wire

[src/softmax_row_tile_planner_top.sv]
// Softmax row tile planner: sequencer around a shared divider and multiplier.
//
// Usage: one request word on req (opcode, row_count, col_count, elem_bytes)
// yields one response word on rsp with the status and every split field.
// req.ready is high only while the sequencer is idle; a word is taken when
// valid and ready are both high. cfg_we writes cfg_wdata into the workspace
// register (reset value 37888 bytes); write it only between requests.
// Sequence: an ordinary plan makes two passes through the radix-2 divider
// (rows per split, then splits and tail) and runs the six products on the
// multiplier. Basic-block shapes add one divider pass per step-down (to test
// divisibility) and one multiplier product per halving step. Requests with
// zero element size or zero columns answer without using the divider.
// Throughput: one request at a time; the divider bounds the rate.
// Reset clears the sequencer and drops any pending response. When the
// receiver stalls, the response holds in the output register, the next
// request may already be accepted and is held before its result loads
// until the previous word is taken.
`default_nettype none
module softmax_row_tile_planner_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [smrtp_pkg::WS_W-1:0]   cfg_wdata,
	smrtp_req_if.sink                         req,
	smrtp_rsp_if.source                       rsp
);
	import smrtp_pkg::*;

	localparam logic [ROW_W-1:0] TILE_R    = ROW_W'(TILE_ROWS);
	localparam logic [ROW_W-1:0] TILE_MASK = ROW_W'(TILE_ROWS - 1);
	localparam logic [COL_W-1:0] UNIT_MASK = COL_W'(BB_UNIT - 1);

	seq_state_t state_q, state_d;

	logic [WS_W-1:0]    ws_q;
	logic [OP_W-1:0]    op_q;
	logic [ROW_W-1:0]   m_q;
	logic [COL_W-1:0]   k_q;
	logic [EB_W-1:0]    eb_q;
	logic [BLK_W-1:0]   blk_q;
	logic [ROW_W-1:0]   s_q;
	logic [ROW_W-1:0]   range_q;
	logic [ROW_W-1:0]   tail_q;
	logic [STAT_W-1:0]  status_q;
	logic [PIDX_W-1:0]  pidx_q;
	logic [ELEMS_W-1:0] prod_q [NUM_PROD];
	logic               out_valid_q;

	logic [STAT_W-1:0]  res_status_q;
	logic [ROW_W-1:0]   res_split_q;
	logic [ROW_W-1:0]   res_range_q;
	logic [ROW_W-1:0]   res_tail_q;
	logic [BLKO_W-1:0]  res_blk_q;
	logic [ELEMS_W-1:0] res_prod_q [NUM_PROD];

	logic               div_start;
	logic [DIV_W-1:0]   div_a;
	logic [DIV_W-1:0]   div_b;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;
	logic [DIV_W-1:0]   div_rem;
	logic               mul_go;
	logic [ROW_W-1:0]   mul_a;
	logic [COL_W-1:0]   mul_b;
	logic [ELEMS_W-1:0] mul_p;
	logic               load_out;

	logic [DIV_W-1:0]   words;
	logic [DIV_W-1:0]   denom;
	logic               grad_half;
	logic [ROW_W-1:0]   s_quo;
	logic [ROW_W-1:0]   s_cap;
	logic [ROW_W-1:0]   s_al;
	logic               bb_skip;
	logic               halve;
	logic               res_ok;

	smrtp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	smrtp_mul u_mul (
		.clk     (clk),
		.go      (mul_go),
		.a       (mul_a),
		.b       (mul_b),
		.product (mul_p)
	);

	// rows-per-split divisor from the buffer cost of one row
	assign words     = DIV_W'(ws_q >> 2);
	assign grad_half = (op_q == OP_W'(1)) && (eb_q == EB_W'(ELEM_HALF));
	assign denom     = grad_half
		? (DIV_W'(blk_q) << 1) + (DIV_W'(k_q) << 1) + DIV_W'(k_q) + DIV_W'(BB_UNIT)
		: DIV_W'(blk_q) + DIV_W'(k_q) + DIV_W'(BB_UNIT);

	// cap at the row count, then align to the tile when below it and above one tile
	assign s_quo = ROW_W'(div_quo);
	assign s_cap = (s_quo > m_q) ? m_q : s_quo;
	assign s_al  = (s_cap < m_q && s_cap > TILE_R) ? (s_cap & ~TILE_MASK) : s_cap;

	assign bb_skip = (s_q <= TILE_R) || ((m_q & TILE_MASK) != '0) || ((k_q & UNIT_MASK) != '0);
	assign halve   = (mul_p >= HALVE_LIMIT);
	assign res_ok  = (status_q == STATUS_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= WS_RESET;
		end else if (cfg_we) begin
			ws_q <= cfg_wdata;
		end
	end

	always_comb begin
		state_d  = state_q;
		div_start = 1'b0;
		div_a    = DIV_W'(m_q);
		div_b    = DIV_W'(s_q);
		mul_go   = 1'b0;
		load_out = 1'b0;
		// product order: m, s, tail against k then blk
		case (pidx_q[2:1])
			2'd0:    mul_a = m_q;
			2'd1:    mul_a = s_q;
			default: mul_a = tail_q;
		endcase
		mul_b = pidx_q[0] ? COL_W'(blk_q) : k_q;

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (eb_q == '0 || k_q == '0) begin
					state_d = ST_DONE;
				end else begin
					div_start = 1'b1;
					div_a     = words;
					div_b     = denom;
					state_d   = ST_WDIV;
				end
			end
			ST_WDIV: begin
				if (div_done) state_d = ST_BB;
			end
			ST_BB: begin
				state_d = bb_skip ? ST_ZCHK : ST_MODCHK;
			end
			ST_MODCHK: begin
				if (s_q == '0) begin
					state_d = ST_ZCHK;
				end else begin
					div_start = 1'b1;
					state_d   = ST_MODW;
				end
			end
			ST_MODW: begin
				if (div_done) state_d = (div_rem != '0) ? ST_MODCHK : ST_HMUL;
			end
			ST_HMUL: begin
				if (s_q == '0) begin
					state_d = ST_ZCHK;
				end else begin
					mul_go  = 1'b1;
					mul_a   = s_q;
					mul_b   = k_q;
					state_d = ST_HCHK;
				end
			end
			ST_HCHK: begin
				state_d = halve ? ST_HMUL : ST_ZCHK;
			end
			ST_ZCHK: begin
				if (s_q == '0) begin
					state_d = ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_RDIV;
				end
			end
			ST_RDIV: begin
				if (div_done) state_d = ST_PROD;
			end
			ST_PROD: begin
				if (pidx_q < PIDX_W'(NUM_PROD)) mul_go = 1'b1;
				if (pidx_q == PIDX_W'(NUM_PROD)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			pidx_q      <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_RDIV) begin
				pidx_q <= '0;
			end else if (state_q == ST_PROD) begin
				pidx_q <= pidx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			op_q  <= req.opcode;
			m_q   <= req.row_count;
			k_q   <= req.col_count;
			eb_q  <= req.elem_bytes;
			blk_q <= blk_of(req.elem_bytes);
		end
		if (state_q == ST_CHECK) begin
			status_q <= (eb_q == '0) ? STATUS_ZERO_ELEM
				: (k_q == '0) ? STATUS_ZERO_DIM : STATUS_OK;
		end
		if (state_q == ST_WDIV && div_done) begin
			s_q <= s_al;
		end
		if (state_q == ST_BB && !bb_skip) begin
			s_q <= s_q & ~TILE_MASK;
		end
		// step down by a tile until the split divides the rows
		if (state_q == ST_MODW && div_done && div_rem != '0) begin
			s_q <= s_q - TILE_R;
		end
		if (state_q == ST_HCHK && halve) begin
			s_q <= s_q >> 1;
		end
		if (state_q == ST_ZCHK && s_q == '0) begin
			status_q <= STATUS_ZERO_DIM;
		end
		if (state_q == ST_RDIV && div_done) begin
			range_q <= ROW_W'(div_quo);
			tail_q  <= ROW_W'(div_rem);
		end
		// capture the product issued in the previous cycle
		if (state_q == ST_PROD && pidx_q != '0) begin
			prod_q[PIDX_W'(pidx_q - 1'b1)] <= mul_p;
		end
		if (load_out) begin
			res_status_q <= status_q;
			res_split_q  <= res_ok ? s_q : '0;
			res_range_q  <= res_ok ? range_q : '0;
			res_tail_q   <= res_ok ? tail_q : '0;
			res_blk_q    <= res_ok ? blk_q[BLKO_W-1:0] : '0;
			for (int i = 0; i < NUM_PROD; i++) begin
				res_prod_q[i] <= res_ok ? prod_q[i] : '0;
			end
		end
	end

	assign req.ready             = (state_q == ST_IDLE);
	assign rsp.valid             = out_valid_q;
	assign rsp.status            = res_status_q;
	assign rsp.split_rows        = res_split_q;
	assign rsp.full_splits       = res_range_q;
	assign rsp.tail_rows         = res_tail_q;
	assign rsp.block_elems       = res_blk_q;
	assign rsp.total_elems       = res_prod_q[0];
	assign rsp.out_max_elems     = res_prod_q[1];
	assign rsp.split_elems       = res_prod_q[2];
	assign rsp.reduce_elems      = res_prod_q[3];
	assign rsp.tail_split_elems  = res_prod_q[4];
	assign rsp.tail_reduce_elems = res_prod_q[5];

endmodule
`default_nettype wire

[src/smrtp_chk.sv]
// Port-level checker for the row tile planner, bound to the top level.
`default_nettype none
`include "softmax_row_tile_planner_top_macros.svh"
module smrtp_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [smrtp_pkg::STAT_W-1:0]  status,
	input wire logic [smrtp_pkg::ROW_W-1:0]   split_rows,
	input wire logic [smrtp_pkg::ROW_W-1:0]   tail_rows,
	input wire logic [smrtp_pkg::ELEMS_W-1:0] total_elems
);
	import smrtp_pkg::*;

	`SMRTP_ASSERT(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready, "ready stayed high after a request word")
	`SMRTP_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(split_rows)), "stalled response word changed")
	`SMRTP_ASSERT_IMPLY(a_ok_split, rsp_valid && status == STATUS_OK, split_rows != '0 && tail_rows < split_rows, "ok plan with bad split or tail")
	`SMRTP_ASSERT_IMPLY(a_err_zero, rsp_valid && status != STATUS_OK, split_rows == '0 && total_elems == '0 && (status == STATUS_ZERO_ELEM || status == STATUS_ZERO_DIM), "error word carries data or unknown status")

endmodule

bind softmax_row_tile_planner_top smrtp_chk u_smrtp_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.split_rows  (rsp.split_rows),
	.tail_rows   (rsp.tail_rows),
	.total_elems (rsp.total_elems)
);
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the softmax row tile planner: every response word is checked against a predicted plan.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import smrtp_pkg::*;

	localparam logic [OP_W-1:0] OP_FWD  = 1'b0;
	localparam logic [OP_W-1:0] OP_GRAD = 1'b1;
	localparam int BUF_PAIR   = 2;
	localparam int BUF_TRIPLE = 3;
	localparam int IDLE_PCT   = 28;
	localparam int PRINT_CAP  = 40;
	localparam int NUM_PHASES = 8;
	localparam int PHASE_LEN  = 244;
	localparam logic [WS_W-1:0] WS_MAX = '1;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [ROW_W-1:0] row_count;
		logic [COL_W-1:0] col_count;
		logic [EB_W-1:0]  elem_bytes;
	} plan_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [ROW_W-1:0]   split_rows;
		logic [ROW_W-1:0]   full_splits;
		logic [ROW_W-1:0]   tail_rows;
		logic [BLKO_W-1:0]  block_elems;
		logic [ELEMS_W-1:0] total_elems;
		logic [ELEMS_W-1:0] out_max_elems;
		logic [ELEMS_W-1:0] split_elems;
		logic [ELEMS_W-1:0] reduce_elems;
		logic [ELEMS_W-1:0] tail_split_elems;
		logic [ELEMS_W-1:0] tail_reduce_elems;
	} plan_rsp_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [WS_W-1:0] cfg_wdata;

	smrtp_req_if req_ch();
	smrtp_rsp_if rsp_ch();

	softmax_row_tile_planner_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	plan_rsp_t       plan_q[$];
	logic [WS_W-1:0] ws_model;
	bit              steady;
	int              err_count;
	int              sent_count;
	int              checked_count;
	int              ws_writes;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Plan one request the way the block does, all products modulo 2^32.
	function automatic plan_rsp_t plan_split(input plan_req_t r, input logic [WS_W-1:0] ws);
		plan_rsp_t   p;
		logic [31:0] m, k, eb, blk, words, denom, s, tail;
		p = '0;
		m = 32'(r.row_count);
		k = 32'(r.col_count);
		eb = 32'(r.elem_bytes);
		if (eb == 0) begin
			p.status = STATUS_ZERO_ELEM;
			return p;
		end
		if (k == 0) begin
			p.status = STATUS_ZERO_DIM;
			return p;
		end
		blk = 32'(BLOCK_BYTES) / eb;
		words = 32'(ws) / 32'(ELEM_FLOAT);
		if (r.opcode == OP_GRAD && eb == 32'(ELEM_HALF))
			denom = blk * BUF_PAIR + k * BUF_TRIPLE + BB_UNIT;
		else
			denom = blk + k + BB_UNIT;
		s = words / denom;
		if (s > m)
			s = m;
		if (s < m && s > TILE_ROWS)
			s = s / TILE_ROWS * TILE_ROWS;
		// Basic-block shapes: step down to a divisor of the rows, then halve.
		if (s > TILE_ROWS && (m % TILE_ROWS) == 0 && (k % BB_UNIT) == 0) begin
			s = s / TILE_ROWS * TILE_ROWS;
			while (s != 0 && (m % s) != 0)
				s = s - TILE_ROWS;
			while (s != 0 && (s * k) >= 32'(HALVE_LIMIT))
				s = s / ELEM_HALF;
		end
		if (s == 0) begin
			p.status = STATUS_ZERO_DIM;
			return p;
		end
		tail = m % s;
		p.status = STATUS_OK;
		p.split_rows = ROW_W'(s);
		p.full_splits = ROW_W'(m / s);
		p.tail_rows = ROW_W'(tail);
		p.block_elems = BLKO_W'(blk);
		p.total_elems = m * k;
		p.out_max_elems = m * blk;
		p.split_elems = s * k;
		p.reduce_elems = s * blk;
		p.tail_split_elems = tail * k;
		p.tail_reduce_elems = tail * blk;
		return p;
	endfunction

	function automatic plan_req_t mk_plan(input logic [OP_W-1:0] op, input int m, input int k,
			input int eb);
		plan_req_t r;
		r.opcode = op;
		r.row_count = ROW_W'(m);
		r.col_count = COL_W'(k);
		r.elem_bytes = EB_W'(eb);
		return r;
	endfunction

	function automatic plan_req_t rand_plan();
		plan_req_t r;
		int        roll;
		roll = $urandom_range(99);
		r.opcode = OP_W'($urandom_range(1));
		if (roll < 40) begin
			// Basic-block shape: rows in whole tiles, columns in whole units.
			if ($urandom_range(3) == 0)
				r.elem_bytes = EB_W'($urandom_range(1, 15));
			else
				r.elem_bytes = $urandom_range(1) ? EB_W'(ELEM_HALF) : EB_W'(ELEM_FLOAT);
			r.row_count = ROW_W'(TILE_ROWS * $urandom_range(1, 2048));
			if ($urandom_range(3) == 0)
				r.col_count = COL_W'(BB_UNIT * $urandom_range(1, 1023));
			else
				r.col_count = COL_W'(BB_UNIT * $urandom_range(1, 16));
		end else if (roll < 75) begin
			r.row_count = ROW_W'($urandom_range(1, 100000));
			r.col_count = COL_W'($urandom_range(1, 4096));
			r.elem_bytes = EB_W'(1 << $urandom_range(3));
		end else if (roll < 90) begin
			r.row_count = ROW_W'($urandom());
			r.col_count = COL_W'($urandom());
			r.elem_bytes = EB_W'($urandom_range(15));
		end else begin
			r.row_count = ROW_W'($urandom_range(0, 5000));
			r.col_count = COL_W'($urandom_range(0, 300));
			r.elem_bytes = EB_W'($urandom_range(15));
			case ($urandom_range(2))
				0: r.elem_bytes = '0;
				1: r.col_count = '0;
				default: r.row_count = '0;
			endcase
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (err_count < PRINT_CAP)
			$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		err_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			note_mismatch(what, got, want);
	endtask

	task automatic check_plan();
		plan_rsp_t want;
		if (plan_q.size() == 0) begin
			note_mismatch("response word with nothing expected", 32'(rsp_ch.status), '0);
			return;
		end
		want = plan_q.pop_front();
		check_field("status", 32'(rsp_ch.status), 32'(want.status));
		check_field("split_rows", 32'(rsp_ch.split_rows), 32'(want.split_rows));
		check_field("full_splits", 32'(rsp_ch.full_splits), 32'(want.full_splits));
		check_field("tail_rows", 32'(rsp_ch.tail_rows), 32'(want.tail_rows));
		check_field("block_elems", 32'(rsp_ch.block_elems), 32'(want.block_elems));
		check_field("total_elems", rsp_ch.total_elems, want.total_elems);
		check_field("out_max_elems", rsp_ch.out_max_elems, want.out_max_elems);
		check_field("split_elems", rsp_ch.split_elems, want.split_elems);
		check_field("reduce_elems", rsp_ch.reduce_elems, want.reduce_elems);
		check_field("tail_split_elems", rsp_ch.tail_split_elems, want.tail_split_elems);
		check_field("tail_reduce_elems", rsp_ch.tail_reduce_elems, want.tail_reduce_elems);
		checked_count++;
	endtask

	// Hold valid across back-to-back words; only the idle loop and drain_plans lower it.
	task automatic send_plan(input plan_req_t r);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= r.opcode;
		req_ch.row_count <= r.row_count;
		req_ch.col_count <= r.col_count;
		req_ch.elem_bytes <= r.elem_bytes;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		plan_q.push_back(plan_split(r, ws_model));
		sent_count++;
	endtask

	task automatic drain_plans();
		req_ch.valid <= 1'b0;
		while (plan_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_workspace(input logic [WS_W-1:0] val);
		drain_plans();
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		ws_model = val;
		ws_writes++;
	endtask

	// Reset workspace value, every operation and the error cases.
	task automatic test_reset_workspace();
		send_plan(mk_plan(OP_FWD, 1000, 128, ELEM_FLOAT));
		send_plan(mk_plan(OP_FWD, 1003, 100, ELEM_FLOAT));
		send_plan(mk_plan(OP_GRAD, 4096, 256, ELEM_HALF));
		send_plan(mk_plan(OP_GRAD, 777, 50, ELEM_FLOAT));
		send_plan(mk_plan(OP_FWD, 72, 64, ELEM_HALF));
		send_plan(mk_plan(OP_FWD, 5, 10, ELEM_FLOAT));
		send_plan(mk_plan(OP_FWD, 300, 20, 3));
		send_plan(mk_plan(OP_GRAD, 123, 7, 15));
		send_plan(mk_plan(OP_FWD, 0, 10, ELEM_FLOAT));
		send_plan(mk_plan(OP_FWD, 100, 10, 0));
		send_plan(mk_plan(OP_GRAD, 100, 0, ELEM_HALF));
		send_plan(mk_plan(OP_FWD, 100, 0, 0));
		send_plan(mk_plan(OP_GRAD, 24'hFFFFFF, 16'hFFFF, 15));
		drain_plans();
	endtask

	// Empty, full and tiny workspace, with wrapping products and halving.
	task automatic test_workspace_extremes();
		write_workspace('0);
		send_plan(mk_plan(OP_FWD, 1000, 64, ELEM_FLOAT));
		send_plan(mk_plan(OP_GRAD, 1000, 64, 0));
		write_workspace(WS_MAX);
		send_plan(mk_plan(OP_FWD, 16384, 64, 8));
		send_plan(mk_plan(OP_GRAD, 24'hFFFFFF, 4000, 1));
		send_plan(mk_plan(OP_GRAD, 24'hFFFFFF, 16'hFFFF, ELEM_HALF));
		send_plan(mk_plan(OP_FWD, 8, 1, 1));
		write_workspace(WS_W'(255));
		send_plan(mk_plan(OP_FWD, 50, 1, 8));
		send_plan(mk_plan(OP_GRAD, 50, 1, ELEM_HALF));
		drain_plans();
	endtask

	// Random requests over several workspace settings.
	task automatic test_random_phases();
		logic [WS_W-1:0] ws;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: ws = WS_RESET;
				1: ws = WS_MAX;
				2: ws = WS_W'($urandom_range(0, 4095));
				3: ws = WS_RESET;
				7: ws = WS_W'($urandom_range(100000, 1048575));
				default: ws = WS_W'($urandom());
			endcase
			write_workspace(ws);
			steady = (ph == 3);
			for (int n = 0; n < PHASE_LEN; n++) begin
				// Let the pipe run dry once mid-phase.
				if (n == PHASE_LEN / 2 && ph == 4)
					drain_plans();
				send_plan(rand_plan());
			end
			steady = 1'b0;
		end
		drain_plans();
	endtask

	initial begin : rsp_side
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				check_plan();
			rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin : watchdog
		#500ms;
		$display("timeout with %0d responses outstanding", plan_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : main
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = '0;
		req_ch.row_count = '0;
		req_ch.col_count = '0;
		req_ch.elem_bytes = '0;
		steady = 1'b0;
		err_count = 0;
		sent_count = 0;
		checked_count = 0;
		ws_writes = 0;
		ws_model = WS_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_workspace();
		test_workspace_extremes();
		test_random_phases();

		repeat (100) @(posedge clk);
		if (plan_q.size() != 0)
			note_mismatch("responses never delivered", 32'(plan_q.size()), '0);
		$display("Run covered %0d plan requests and %0d checked responses over %0d workspace writes",
			sent_count, checked_count, ws_writes);
		$display("Both opcodes, error statuses, basic-block step-down and halving were exercised");
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

[softmax_row_tile_planner_top.f]
+incdir+src
src/smrtp_pkg.sv
src/smrtp_if.sv
src/smrtp_div.sv
src/smrtp_mul.sv
src/softmax_row_tile_planner_top.sv
src/smrtp_chk.sv
bench/tb.sv
